[hdl/assert_macros.svh]
// assertion macros for the adaptive gamma-rice encoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on clk_i, off while in reset
`define AGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication with same-cycle consequent
`define AGR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hdl/agr_pkg.sv]
// shared constants and types of the adaptive gamma-rice encoder
`timescale 1ns / 1ps

package agr_pkg;

  localparam int DEFAULT_WORD_BITS = 32;
  localparam int QUEUE_DEPTH       = 4;

  localparam int S_TDATA_W  = 32;
  localparam int CHUNK_BITS = 32;
  localparam int LEN_W      = 6;
  localparam int KAFT_W     = 6;
  localparam int LEN_LSB    = CHUNK_BITS;
  localparam int KAFT_LSB   = LEN_LSB + LEN_W;
  localparam int M_TDATA_W  = ((KAFT_LSB + KAFT_W + 7) / 8) * 8;

  localparam int MAX_CHUNKS = 3;
  localparam int CNT_W      = $clog2(MAX_CHUNKS);

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int INIT_K_W    = 6;
  localparam int THR_W       = 8;

  localparam logic [INIT_K_W-1:0] INIT_K_RESET   = '0;
  localparam logic [THR_W-1:0]    LOW_THR_RESET  = 8'd0;
  localparam logic [THR_W-1:0]    HIGH_THR_RESET = 8'd7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_INITIAL_K = 2'd0,
    CFG_LOW_THR   = 2'd1,
    CFG_HIGH_THR  = 2'd2
  } cfg_reg_e;

endpackage

[hdl/agr_fifo.sv]
// small flop-based queue between front and back
`timescale 1ns / 1ps

module agr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             valid_o
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW:0]      wr_ptr_q, wr_ptr_d;
  logic [AW:0]      rd_ptr_q, rd_ptr_d;

  assign full_o  = (wr_ptr_q[AW] != rd_ptr_q[AW]) && (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
  assign valid_o = (wr_ptr_q != rd_ptr_q);
  assign rdata_o = mem_q[rd_ptr_q[AW-1:0]];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i && !full_o) begin
      wr_ptr_d = wr_ptr_q + (AW+1)'(1);
    end
    if (pop_i && valid_o) begin
      rd_ptr_d = rd_ptr_q + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q[AW-1:0]] <= wdata_i;
    end
  end

endmodule

[hdl/agr_front.sv]
// front end: config registers, k tracking, code value and length per request
`timescale 1ns / 1ps

module agr_front #(
  parameter int WORD_BITS = agr_pkg::DEFAULT_WORD_BITS,
  parameter int ENT_W     = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [agr_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [agr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [agr_pkg::S_TDATA_W-1:0]   value_i,
  input  logic                           restart_i,
  output logic                           push_o,
  output logic [ENT_W-1:0]               push_data_o,
  input  logic                           full_i
);
  import agr_pkg::*;

  localparam int KW  = $clog2(WORD_BITS + 1);
  localparam int VW  = WORD_BITS + 1;
  localparam int LW  = $clog2(2 * WORD_BITS + 1);
  localparam int BLW = $clog2(VW + 1);

  logic [INIT_K_W-1:0] init_k_q;
  logic [THR_W-1:0]    low_q, high_q;
  logic [KW-1:0]       cur_k_q;

  logic [KW-1:0]        k_init, k_cur, k_dn, k_nx;
  logic [WORD_BITS-1:0] val_w, quo;
  logic                 all_ones, accept;
  logic [VW-1:0]        v_code;

  logic                 s1_valid_q;
  logic [VW-1:0]        v_q;
  logic [KW-1:0]        k_q;
  logic                 ao_q;
  logic [KAFT_W-1:0]    kaft_q;

  logic [BLW-1:0]       bl;
  logic [LW-1:0]        code_len;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_k_q <= INIT_K_RESET;
      low_q    <= LOW_THR_RESET;
      high_q   <= HIGH_THR_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_INITIAL_K: init_k_q <= cfg_data_i[INIT_K_W-1:0];
        CFG_LOW_THR:   low_q    <= cfg_data_i[THR_W-1:0];
        CFG_HIGH_THR:  high_q   <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // classify: k, quotient, adapted k, code value
  always_comb begin
    k_init   = (int'(init_k_q) > WORD_BITS) ? KW'(WORD_BITS) : KW'(init_k_q);
    k_cur    = restart_i ? k_init : cur_k_q;
    val_w    = WORD_BITS'(value_i);
    quo      = (k_cur == KW'(WORD_BITS)) ? '0 : (val_w >> k_cur);
    all_ones = (k_cur == '0) && (&val_w);
    k_dn     = ((quo <= WORD_BITS'(low_q)) && (k_cur != '0)) ? k_cur - KW'(1) : k_cur;
    k_nx     = ((quo >= WORD_BITS'(high_q)) && (k_dn != KW'(WORD_BITS))) ?
               k_dn + KW'(1) : k_dn;
    v_code   = all_ones ? VW'(1) : VW'(val_w) + (VW'(1) << k_cur);
  end

  assign in_ready_o = !s1_valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = s1_valid_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_k_q    <= KW'(INIT_K_RESET);
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cur_k_q    <= k_nx;
        s1_valid_q <= 1'b1;
      end else if (push_o) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q    <= v_code;
      k_q    <= k_cur;
      ao_q   <= all_ones;
      kaft_q <= KAFT_W'(k_nx);
    end
  end

  // code length: leading zeros plus significant bits of the code value, WORD_BITS+1 for all ones at k=0
  always_comb begin
    bl = '0;
    for (int i = 0; i < VW; i++) begin
      if (v_q[i]) begin
        bl = BLW'(i + 1);
      end
    end
    if (ao_q) begin
      code_len = LW'(WORD_BITS + 1);
    end else begin
      code_len = (LW'(bl) << 1) - LW'(k_q) - LW'(1);
    end
  end

  assign push_data_o = {kaft_q, code_len, v_q};

endmodule

[hdl/agr_back.sv]
// back end: slices each codeword into chunks behind an output register
`timescale 1ns / 1ps

module agr_back #(
  parameter int WORD_BITS = agr_pkg::DEFAULT_WORD_BITS,
  parameter int ENT_W     = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  logic [ENT_W-1:0]              head_data_i,
  output logic                          pop_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [agr_pkg::M_TDATA_W-1:0] m_data_o,
  output logic                          m_last_o
);
  import agr_pkg::*;

  localparam int VW   = WORD_BITS + 1;
  localparam int LW   = $clog2(2 * WORD_BITS + 1);
  localparam int RW   = LW + 2;
  localparam int BUFW = (VW > CHUNK_BITS) ? VW : CHUNK_BITS;
  localparam int CSH  = $clog2(CHUNK_BITS);

  logic [VW-1:0]         v;
  logic [LW-1:0]         code_len;
  logic [KAFT_W-1:0]     kaft;

  logic [CNT_W-1:0]      chunk_q, chunk_d;
  logic [RW-1:0]         rem, shamt;
  logic [LEN_W-1:0]      n;
  logic [BUFW-1:0]       shifted;
  logic [CHUNK_BITS-1:0] mask, bits;
  logic                  last, load;

  logic                  out_valid_q;
  logic [CHUNK_BITS-1:0] bits_q;
  logic [LEN_W-1:0]      len_q;
  logic                  last_q;
  logic [KAFT_W-1:0]     kaft_q;

  assign v        = head_data_i[VW-1:0];
  assign code_len = head_data_i[VW +: LW];
  assign kaft     = head_data_i[VW+LW +: KAFT_W];

  always_comb begin
    rem     = RW'(code_len) - (RW'(chunk_q) << CSH);
    n       = (rem > RW'(CHUNK_BITS)) ? LEN_W'(CHUNK_BITS) : LEN_W'(rem);
    shamt   = rem - RW'(n);
    shifted = BUFW'(v) >> shamt;
    mask    = {CHUNK_BITS{1'b1}} >> (LEN_W'(CHUNK_BITS) - n);
    bits    = shifted[CHUNK_BITS-1:0] & mask;
    last    = (rem <= RW'(CHUNK_BITS)) || (chunk_q == CNT_W'(MAX_CHUNKS - 1));
  end

  assign load  = head_valid_i && (!out_valid_q || m_ready_i);
  assign pop_o = load && last;

  always_comb begin
    chunk_d = chunk_q;
    if (load) begin
      chunk_d = last ? '0 : chunk_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      chunk_q <= chunk_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bits_q <= bits;
      len_q  <= n;
      last_q <= last;
      kaft_q <= kaft;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_last_o  = last_q;
  assign m_data_o  = M_TDATA_W'({kaft_q, len_q, bits_q});

endmodule

[hdl/adaptive_gamma_rice_encoder.sv]
// top level of the adaptive gamma-rice encoder
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata value, tuser restart
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata chunk, tlast last chunk
//  cfg       in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// front takes one value per cycle unless the queue is full; back sends one chunk per cycle
// while m_axis_tready is high, so a value is sent as ceil(len/32) chunks, up to 3. the first
// chunk of a value passes the front stage register, the queue and the output chunk register.
// reset is asynchronous and clears k, the config registers and the queue.
// a 4-entry queue lets the front keep taking values while the output stalls.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adaptive_gamma_rice_encoder #(
  parameter int WORD_BITS   = agr_pkg::DEFAULT_WORD_BITS,
  parameter int QUEUE_DEPTH = agr_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [agr_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [agr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [agr_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // value[31:0]
  input  logic                            s_axis_tuser,  // restart
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [agr_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // chunk_bits, chunk_len, k_after, pad
  output logic                            m_axis_tlast
);
  import agr_pkg::*;

  localparam int VW    = WORD_BITS + 1;
  localparam int LW    = $clog2(2 * WORD_BITS + 1);
  localparam int ENT_W = KAFT_W + LW + VW;

  logic             push, full, pop, head_valid;
  logic [ENT_W-1:0] push_data, head_data;

  assign cfg_ready_o = 1'b1;

  agr_front #(
    .WORD_BITS (WORD_BITS),
    .ENT_W     (ENT_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .value_i     (s_axis_tdata),
    .restart_i   (s_axis_tuser),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  agr_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (head_data),
    .valid_o (head_valid)
  );

  agr_back #(
    .WORD_BITS (WORD_BITS),
    .ENT_W     (ENT_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_o     (m_axis_tdata),
    .m_last_o     (m_axis_tlast)
  );

  `AGR_ASSERT_IMPL(a_len_range, m_axis_tvalid, (m_axis_tdata[LEN_LSB +: LEN_W] != '0) && (m_axis_tdata[LEN_LSB +: LEN_W] <= LEN_W'(CHUNK_BITS)), "chunk length out of range")
  `AGR_ASSERT_IMPL(a_full_chunk, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[LEN_LSB +: LEN_W] == LEN_W'(CHUNK_BITS), "non-final chunk is not full")
  `AGR_ASSERT_IMPL(a_k_range, m_axis_tvalid, int'(m_axis_tdata[KAFT_LSB +: KAFT_W]) <= WORD_BITS, "k beyond word size")
  `AGR_ASSERT(a_pop_needs_head, !pop || head_valid, "queue popped while empty")

endmodule
